/* rtl/core/drp_pkg.sv */
// Shared types and constants for the disparity reprojection block.
`timescale 1ns / 1ps
package drp_pkg;

  localparam int Q_REGS = 8;
  localparam int CFG_IDX_W = 4;
  localparam int ACC_W = 50;   // signed dot product, 20 fraction bits
  localparam int MAG_W = 49;   // magnitude of a dot product
  localparam int FRAC_W = 16;
  localparam int QUO_W = 32;   // quotient bits, one per cell
  localparam int STEPS = QUO_W;

  localparam logic signed [31:0] Z_MIN = 32'sd32768;      // 0.5
  localparam logic signed [31:0] Z_FAR = 32'sd6553600;    // 100.0
  localparam logic signed [15:0] D_MIN = 16'sd48;         // 3.0 in Q12.4
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef logic [Q_REGS-1:0][63:0] qbank_t;

  localparam qbank_t Q_RESET = {
    64'h0000_0000_0001_0000,   // row 3, entries 2 and 3
    64'h0000_0000_0000_0000,   // row 3, entries 0 and 1
    64'h0000_0000_0001_0000,   // row 2, entries 2 and 3
    64'h0000_0000_0000_0000,   // row 2, entries 0 and 1
    64'h0000_0000_0000_0000,   // row 1, entries 2 and 3
    64'h0001_0000_0000_0000,   // row 1, entries 0 and 1
    64'h0000_0000_0000_0000,   // row 0, entries 2 and 3
    64'h0000_0000_0001_0000    // row 0, entries 0 and 1
  };

  typedef struct packed {
    logic [11:0]        column;
    logic [11:0]        row;
    logic signed [15:0] disparity;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic               depth_replaced;
    logic               coord_saturated;
    logic               zero_weight;
  } point_t;

  // One coordinate in flight through the divider chain.
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [QUO_W-1:0] nq;        // dividend bits shift out, quotient bits shift in
    logic             neg;
    logic             force_sat;
    logic             force_zero;
  } lane_t;

  typedef struct packed {
    logic               valid;
    lane_t [2:0]        lane;
    logic [MAG_W-1:0]   div;
    logic signed [15:0] disparity;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               wzero;
  } tok_t;

endpackage

/* rtl/core/drp_dot.sv */
// Front end: clamp, matrix-vector products, magnitudes and divider setup.
`timescale 1ns / 1ps
module drp_dot #(
  parameter int COLUMN_LIMIT = 4096,
  parameter int ROW_LIMIT = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            pix_valid,
  input  drp_pkg::pixel_t pix,
  input  drp_pkg::qbank_t q_regs,
  output drp_pkg::tok_t   tok_out
);
  import drp_pkg::*;

  localparam logic [12:0] COL_CAP = (COLUMN_LIMIT >= 4096) ? 13'd4096 : 13'(COLUMN_LIMIT);
  localparam logic [12:0] ROW_CAP = (ROW_LIMIT >= 4096) ? 13'd4096 : 13'(ROW_LIMIT);

  logic [11:0] col_c, row_c;

  // stage valids
  logic v1, v2, v3, v4, v5, v6;

  // stage 1: clamped pixel
  logic [11:0]        col1, row1;
  logic signed [15:0] d1, d2, d3, d4, d5;
  logic [23:0]        rgb1, rgb2, rgb3, rgb4, rgb5;

  logic signed [31:0]      ent [4][4];
  logic signed [ACC_W-1:0] prod [4][4];
  logic signed [ACC_W-1:0] sum_a [4], sum_b [4];
  logic signed [ACC_W-1:0] acc [4];
  logic [MAG_W-1:0]        mag [4];
  logic [3:0]              sgn, nz;
  logic                    wzero5;
  tok_t                    tok6;

  assign col_c = ({1'b0, pix.column} >= COL_CAP) ? 12'(COL_CAP - 13'd1) : pix.column;
  assign row_c = ({1'b0, pix.row} >= ROW_CAP) ? 12'(ROW_CAP - 13'd1) : pix.row;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ent[k][0] = $signed(q_regs[3'(2 * k)][31:0]);
      ent[k][1] = $signed(q_regs[3'(2 * k)][63:32]);
      ent[k][2] = $signed(q_regs[3'(2 * k + 1)][31:0]);
      ent[k][3] = $signed(q_regs[3'(2 * k + 1)][63:32]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= pix_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col1 <= col_c;
      row1 <= row_c;
      d1 <= pix.disparity;
      rgb1 <= {pix.red, pix.green, pix.blue};

      for (int k = 0; k < 4; k++) begin
        prod[k][0] <= ent[k][0] * $signed({1'b0, col1, 4'b0});
        prod[k][1] <= ent[k][1] * $signed({1'b0, row1, 4'b0});
        prod[k][2] <= ent[k][2] * d1;
        prod[k][3] <= ACC_W'($signed({ent[k][3], 4'b0}));
      end
      d2 <= d1;
      rgb2 <= rgb1;

      for (int k = 0; k < 4; k++) begin
        sum_a[k] <= prod[k][0] + prod[k][1];
        sum_b[k] <= prod[k][2] + prod[k][3];
      end
      d3 <= d2;
      rgb3 <= rgb2;

      for (int k = 0; k < 4; k++) begin
        acc[k] <= sum_a[k] + sum_b[k];
      end
      d4 <= d3;
      rgb4 <= rgb3;

      for (int k = 0; k < 4; k++) begin
        mag[k] <= acc[k][ACC_W-1] ? MAG_W'(-acc[k]) : MAG_W'(acc[k]);
        sgn[k] <= acc[k][ACC_W-1];
        nz[k] <= (acc[k] != '0);
      end
      wzero5 <= (acc[3] == '0);
      d5 <= d4;
      rgb5 <= rgb4;

      // quotient overflows 16 integer bits when a / 2^16 >= b
      for (int l = 0; l < 3; l++) begin
        tok6.lane[l].rem <= MAG_W'(mag[l][MAG_W-1:FRAC_W]);
        tok6.lane[l].nq <= {mag[l][FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
        tok6.lane[l].neg <= sgn[l] ^ sgn[3];
        tok6.lane[l].force_zero <= wzero5 && !nz[l];
        tok6.lane[l].force_sat <= wzero5 ? nz[l] :
                                  (MAG_W'(mag[l][MAG_W-1:FRAC_W]) >= mag[3]);
      end
      tok6.div <= mag[3];
      tok6.disparity <= d5;
      {tok6.red, tok6.green, tok6.blue} <= rgb5;
      tok6.wzero <= wzero5;
      tok6.valid <= 1'b0;
    end
  end

  always_comb begin
    tok_out = tok6;
    tok_out.valid = v6;
  end

endmodule

/* rtl/core/drp_cell.sv */
// One restoring-division cell: one quotient bit for each of X, Y and Z.
`timescale 1ns / 1ps
module drp_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  drp_pkg::tok_t tok_in,
  output drp_pkg::tok_t tok_out
);
  import drp_pkg::*;

  logic [MAG_W:0] trial [3];
  logic [2:0]     qbit;
  tok_t           tok_next;
  tok_t           pay_q;
  logic           valid_q;

  always_comb begin
    tok_next = tok_in;
    for (int l = 0; l < 3; l++) begin
      trial[l] = {tok_in.lane[l].rem, tok_in.lane[l].nq[QUO_W-1]};
      qbit[l] = (trial[l] >= {1'b0, tok_in.div});
      tok_next.lane[l].rem = qbit[l] ? MAG_W'(trial[l] - {1'b0, tok_in.div})
                                     : trial[l][MAG_W-1:0];
      tok_next.lane[l].nq = {tok_in.lane[l].nq[QUO_W-2:0], qbit[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_q <= tok_next;
    end
  end

  always_comb begin
    tok_out = pay_q;
    tok_out.valid = valid_q;
  end

  // a live division keeps its partial remainder below the divisor
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    valid_q && !pay_q.lane[0].force_sat && !pay_q.lane[0].force_zero
      |-> pay_q.lane[0].rem < pay_q.div)
    else $error("partial remainder not below divisor");

endmodule

/* rtl/core/disparity_reproject_to_3d.sv */
// Pipeline: 6 front-end stages, 32 divider cells and 2 rounding/saturation
// stages lie between an accepted pixel and its point.
// Throughput: one pixel per cycle while point_stall is not holding the output;
// the 32-cell divider chain carries one quotient bit per cell for X, Y and Z.
// Reset (rst, synchronous): pipeline emptied, matrix returns to its defaults.
`timescale 1ns / 1ps
module disparity_reproject_to_3d #(
  parameter int COLUMN_LIMIT = 4096,
  parameter int ROW_LIMIT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  drp_pkg::pixel_t                pixel,
  output logic                           point_valid,
  input  logic                           point_stall,
  output drp_pkg::point_t                point,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [drp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data
);
  import drp_pkg::*;

  qbank_t q_regs;
  logic   en;
  tok_t   chain [STEPS+1];

  // rounding stage
  logic               f1_v;
  logic [QUO_W:0]     f1_mag [3];
  logic [2:0]         f1_neg, f1_fsat, f1_fzero;
  logic signed [15:0] f1_d;
  logic [23:0]        f1_rgb;
  logic               f1_wz;

  logic               out_v;
  point_t             out_q;
  logic [31:0]        res [3];
  logic [2:0]         sat_c;
  logic               repl;

  assign en = !(out_v && point_stall);
  assign pixel_stall = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_regs <= Q_RESET;
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(Q_REGS))) begin
      q_regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  drp_dot #(
    .COLUMN_LIMIT (COLUMN_LIMIT),
    .ROW_LIMIT    (ROW_LIMIT)
  ) u_dot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .pix_valid (pixel_valid),
    .pix       (pixel),
    .q_regs    (q_regs),
    .tok_out   (chain[0])
  );

  for (genvar s = 0; s < STEPS; s++) begin : g_cell
    drp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tok_in  (chain[s]),
      .tok_out (chain[s+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      f1_v <= chain[STEPS].valid;
      out_v <= f1_v;
    end
  end

  // round half away from zero: add one when 2*rem >= divisor
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        f1_mag[l] <= {1'b0, chain[STEPS].lane[l].nq} +
                     (QUO_W+1)'({chain[STEPS].lane[l].rem, 1'b0} >= {1'b0, chain[STEPS].div});
        f1_neg[l] <= chain[STEPS].lane[l].neg;
        f1_fsat[l] <= chain[STEPS].lane[l].force_sat;
        f1_fzero[l] <= chain[STEPS].lane[l].force_zero;
      end
      f1_d <= chain[STEPS].disparity;
      f1_rgb <= {chain[STEPS].red, chain[STEPS].green, chain[STEPS].blue};
      f1_wz <= chain[STEPS].wzero;
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sat_c[l] = 1'b0;
      if (f1_fzero[l]) begin
        res[l] = '0;
      end else if (f1_fsat[l]) begin
        res[l] = f1_neg[l] ? SAT_NEG : SAT_POS;
        sat_c[l] = 1'b1;
      end else if (!f1_neg[l] && (f1_mag[l] > {1'b0, SAT_POS})) begin
        res[l] = SAT_POS;
        sat_c[l] = 1'b1;
      end else if (f1_neg[l] && (f1_mag[l] > {1'b0, SAT_NEG})) begin
        res[l] = SAT_NEG;
        sat_c[l] = 1'b1;
      end else begin
        res[l] = f1_neg[l] ? -f1_mag[l][QUO_W-1:0] : f1_mag[l][QUO_W-1:0];
      end
    end
    repl = ($signed(res[2]) < Z_MIN) || (f1_d < D_MIN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q.point_x <= $signed(res[0]);
      out_q.point_y <= $signed(res[1]);
      out_q.point_z <= repl ? Z_FAR : $signed(res[2]);
      {out_q.red_out, out_q.green_out, out_q.blue_out} <= f1_rgb;
      out_q.depth_replaced <= repl;
      out_q.coord_saturated <= sat_c[0] || sat_c[1] || (sat_c[2] && !repl);
      out_q.zero_weight <= f1_wz;
    end
  end

  assign point_valid = out_v;
  assign point = out_q;

  a_repl_far: assert property (@(posedge clk) disable iff (rst)
    point_valid && point.depth_replaced |-> point.point_z == Z_FAR)
    else $error("replaced depth is not the far value");

  a_z_floor: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point.depth_replaced |-> point.point_z >= Z_MIN)
    else $error("kept depth below the near limit");

  a_wzero_sat: assert property (@(posedge clk) disable iff (rst)
    point_valid && point.zero_weight && (point.point_x != 0) |-> point.coord_saturated)
    else $error("zero weight clip without saturation flag");

endmodule

/* test/disparity_reproject_to_3d_tb.sv */
// Self-checking testbench for the disparity reprojection block.
`timescale 1ns / 1ps
module disparity_reproject_to_3d_tb;
  import drp_pkg::*;

  localparam int COL_LIM = 4096;
  localparam int ROW_LIM = 4096;
  localparam int LATENCY = 40;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint NEG_MAX = -64'sd2147483648;

  typedef enum logic [3:0] {
    R0_C01 = 4'd0, R0_C23 = 4'd1, R1_C01 = 4'd2, R1_C23 = 4'd3,
    R2_C01 = 4'd4, R2_C23 = 4'd5, R3_C01 = 4'd6, R3_C23 = 4'd7,
    BAD_IDX = 4'd9
  } qreg_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  pixel_t pixel = '0;
  logic point_valid;
  logic point_stall = 1'b0;
  point_t point;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  disparity_reproject_to_3d dut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [63:0] matrix [8];
  point_t expected_points [$];
  int errors = 0;
  longint cycles = 0;
  bit stall_hold = 0;

  function automatic longint entry(input int r, input int c);
    logic [63:0] w;
    w = matrix[2 * r + c / 2];
    return (c % 2) ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
  endfunction

  // Divide with round half away from zero, saturate to Q16.16.
  function automatic longint divide_q16(input longint n, input longint w, inout bit sat);
    bit neg;
    logic [63:0] a, b, q, r, mag;
    neg = (n < 0) != (w < 0);
    a = (n < 0) ? -n : n;
    b = (w < 0) ? -w : w;
    q = a / b;
    r = a % b;
    if (q >= 64'h10000) begin
      sat = 1;
      return neg ? NEG_MAX : POS_MAX;
    end
    mag = q;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      mag = mag << 1;
      if (r >= b) begin
        r = r - b;
        mag[0] = 1'b1;
      end
    end
    if ((r << 1) >= b) mag = mag + 1;
    if (!neg && mag > 64'd2147483647) begin
      sat = 1;
      return POS_MAX;
    end
    if (neg && mag > 64'd2147483648) begin
      sat = 1;
      return NEG_MAX;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic point_t reproject(input pixel_t p);
    point_t o;
    longint col, rw, d, acc[4], res[3];
    bit sat[3];
    bit wz, repl;
    col = p.column;
    rw = p.row;
    d = longint'(p.disparity);
    if (col >= COL_LIM) col = COL_LIM - 1;
    if (rw >= ROW_LIM) rw = ROW_LIM - 1;
    for (int k = 0; k < 4; k++)
      acc[k] = entry(k, 0) * col * 16 + entry(k, 1) * rw * 16 + entry(k, 2) * d
             + entry(k, 3) * 16;
    wz = (acc[3] == 0);
    for (int k = 0; k < 3; k++) begin
      sat[k] = 0;
      if (wz) begin
        if (acc[k] == 0) res[k] = 0;
        else begin
          sat[k] = 1;
          res[k] = (acc[k] > 0) ? POS_MAX : NEG_MAX;
        end
      end else res[k] = divide_q16(acc[k], acc[3], sat[k]);
    end
    repl = (res[2] < 32768) || (d < 48);
    if (repl) begin
      res[2] = 6553600;
      sat[2] = 0;
    end
    o.point_x = res[0][31:0];
    o.point_y = res[1][31:0];
    o.point_z = res[2][31:0];
    o.red_out = p.red;
    o.green_out = p.green;
    o.blue_out = p.blue;
    o.depth_replaced = repl;
    o.coord_saturated = sat[0] | sat[1] | sat[2];
    o.zero_weight = wz;
    return o;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) :
           (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 2));
  endfunction

  task automatic write_reg(input qreg_e idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx < 8) matrix[idx] = data;
    @(posedge clk);
  endtask

  // Drop valid for a gap; with no gap the next item follows directly.
  task automatic idle(input int n);
    if (n > 0) begin
      pixel_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold input until all points are back, then let the pipe drain.
  task automatic drain();
    pixel_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic send_pixel(input pixel_t p, input bit check_known, input point_t known);
    point_t e;
    e = reproject(p);
    if (check_known && e !== known) begin
      $display("%0t table mismatch: expected %h predictor %h", $time, known, e);
      errors++;
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    expected_points.push_back(check_known ? known : e);
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
  endtask

  // Receiver: compare each accepted point with the oldest expected one.
  always @(posedge clk) begin
    point_t e;
    cycles <= cycles + 1;
    if (!rst && point_valid && !point_stall) begin
      if (expected_points.size() == 0) begin
        $display("%0t unexpected point %h", $time, point);
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (point.point_x !== e.point_x || point.point_y !== e.point_y ||
            point.point_z !== e.point_z || point.red_out !== e.red_out ||
            point.green_out !== e.green_out || point.blue_out !== e.blue_out ||
            point.depth_replaced !== e.depth_replaced ||
            point.coord_saturated !== e.coord_saturated ||
            point.zero_weight !== e.zero_weight) begin
          $display("%0t point mismatch: expected %h actual %h", $time, e, point);
          errors++;
        end
      end
    end
    point_stall <= stall_hold ? 1'b0 : ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("disparity_reproject_to_3d regression: fail");
      $finish;
    end
  end

  typedef struct {
    pixel_t p;
    bit known;
    point_t o;
  } row_t;

  function automatic point_t pt(input logic [31:0] x, y, z, input pixel_t p,
                                input bit r, s, w);
    point_t o;
    o = '{x, y, z, p.red, p.green, p.blue, r, s, w};
    return o;
  endfunction

  function automatic logic [63:0] rand_reg();
    logic [31:0] lo, hi;
    case ($urandom_range(0, 5))
      0: lo = 32'h0;
      1: lo = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2, 3: lo = $signed($urandom_range(0, 262143)) - 131072;
      default: lo = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: hi = 32'h0;
      1: hi = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2, 3: hi = $signed($urandom_range(0, 262143)) - 131072;
      default: hi = $urandom;
    endcase
    return {hi, lo};
  endfunction

  initial begin
    row_t tbl [$];
    pixel_t p;
    point_t none;
    none = '0;
    matrix = '{64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
               64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0000_0000_0001_0000};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset matrix: X = col / d, Y = row / d, Z = 1.0 unless replaced.
    p = '{12'd10, 12'd20, 16'sd64, 8'h00, 8'hFF, 8'h5A};
    tbl.push_back('{p, 1, pt(32'd10 << 14, 32'd20 << 14, 32'h10000, p, 0, 0, 0)});
    p = '{12'd0, 12'd0, 16'sd0, 8'hFF, 8'h00, 8'hA5};
    tbl.push_back('{p, 1, pt(0, 0, 32'd6553600, p, 1, 0, 1)});
    p = '{12'd4095, 12'd4095, 16'sd0, 8'h12, 8'h34, 8'h56};
    tbl.push_back('{p, 1, pt(SAT_POS, SAT_POS, 32'd6553600, p, 1, 1, 1)});
    p = '{12'd0, 12'd0, 16'sd47, 8'h01, 8'h02, 8'h03};
    tbl.push_back('{p, 1, pt(0, 0, 32'd6553600, p, 1, 0, 0)});
    p = '{12'd4095, 12'd0, 16'sd48, 8'h80, 8'h7F, 8'h01};
    tbl.push_back('{p, 0, none});
    p = '{12'd4095, 12'd4095, 16'sh7FFF, 8'hFF, 8'hFF, 8'hFF};
    tbl.push_back('{p, 0, none});
    p = '{12'd5, 12'd7, 16'sh8000, 8'h00, 8'h00, 8'h00};
    tbl.push_back('{p, 0, none});
    p = '{12'd1, 12'd4095, -16'sd1, 8'h55, 8'hAA, 8'h0F};
    tbl.push_back('{p, 0, none});
    foreach (tbl[i]) begin
      idle(short_gap());
      send_pixel(tbl[i].p, tbl[i].known, tbl[i].o);
    end
    drain();

    // Bad index is dropped; then each register at extremes.
    write_reg(BAD_IDX, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(R0_C01, 64'h7FFF_FFFF_8000_0000);
    write_reg(R0_C23, 64'h8000_0000_7FFF_FFFF);
    write_reg(R1_C01, 64'hFFFF_FFFF_0000_0001);
    write_reg(R1_C23, 64'h0001_0000_FFFF_0000);
    write_reg(R2_C01, 64'h0000_0000_0000_0000);
    write_reg(R2_C23, 64'h7FFF_FFFF_7FFF_FFFF);
    write_reg(R3_C01, 64'h0000_0000_0000_0000);
    write_reg(R3_C23, 64'h0000_0000_0000_0000);
    for (int i = 0; i < 10; i++) begin
      p = {$urandom, $urandom};
      send_pixel(p, 0, none);
    end
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      for (int r = 0; r < 8; r++)
        if (phase == 0 || $urandom_range(0, 2) == 0) write_reg(qreg_e'(r), rand_reg());
      if (phase == 9) write_reg(R3_C23, 64'h0001_0000_0000_0000);
      for (int i = 0; i < 150; i++) begin
        idle(short_gap());
        p = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) p.disparity = 16'($urandom_range(0, 4000));
        if ($urandom_range(0, 9) == 0) p.disparity = 16'($urandom_range(40, 56));
        send_pixel(p, 0, none);
        if (i == 75 && phase == 4) begin
          pixel_valid <= 1'b0;
          stall_hold = 1;
          while (expected_points.size() != 0) @(posedge clk);
          stall_hold = 0;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("disparity_reproject_to_3d regression: pass");
    end else begin
      $display("disparity_reproject_to_3d regression: fail");
    end
    $finish;
  end
endmodule
